// File: hdl/mtep_pkg.sv
// Shared types, constants and helper functions for the MIDI track event parser.
`default_nettype none

package mtep_pkg;

  // Parser phases, one per kind of byte the track body can hold next.
  typedef enum logic [2:0] {
    PH_DELTA,
    PH_EVENT,
    PH_META_TYPE,
    PH_META_LEN,
    PH_SYSEX_LEN,
    PH_TEMPO,
    PH_SKIP,
    PH_PARAMS
  } phase_e;

  // Outcome of one byte of a variable-length quantity.
  typedef enum logic [1:0] {
    VLQ_MORE,
    VLQ_DONE,
    VLQ_BAD
  } vlq_e;

  // Result kinds.
  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_TEMPO   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // End reasons.
  localparam logic [1:0] REASON_RUNNING   = 2'd0;
  localparam logic [1:0] REASON_END_META  = 2'd1;
  localparam logic [1:0] REASON_DATA_END  = 2'd2;
  localparam logic [1:0] REASON_MALFORMED = 2'd3;

  // Special byte values.
  localparam logic [7:0] META_BYTE     = 8'hFF;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE  = 8'hF7;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_END      = 8'h2F;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;

  localparam int unsigned VLQ_W   = 28;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned TEMPO_W = 24;

  // Parser state carried from byte to byte.
  typedef struct packed {
    phase_e               phase;
    logic [7:0]           run_status;
    logic [VLQ_W-1:0]     vlq_value;
    logic [VLQ_W-1:0]     pending_delta;
    logic [7:0]           meta_kind;
    logic [LEN_W-1:0]     skip_remaining;
    logic [7:0]           param0;
    logic [7:0]           param1;
    logic [1:0]           data_needed;
    logic [1:0]           params_got;
    logic [TEMPO_W-1:0]   tempo_acc;
    logic [LEN_W-1:0]     byte_pos;
    logic                 track_done;
  } parse_state_t;

  // One result item.
  typedef struct packed {
    logic [1:0]           kind;
    logic [VLQ_W-1:0]     delta_ticks;
    logic [7:0]           status_byte;
    logic [7:0]           first_param;
    logic [7:0]           second_param;
    logic [1:0]           data_read;
    logic [TEMPO_W-1:0]   tempo_us;
    logic [1:0]           end_reason;
  } result_t;

  // Program change and channel pressure carry one data byte, all else two.
  function automatic logic [1:0] needed_for(input logic [7:0] status);
    logic [1:0] n;
    n = 2'd2;
    if (status[7:4] inside {TYPE_PROGRAM, TYPE_PRESSURE}) begin
      n = 2'd1;
    end
    return n;
  endfunction

  // Track end with no event attached.
  function automatic result_t end_item(input logic [VLQ_W-1:0] delta,
                                       input logic [1:0] reason);
    result_t r;
    r             = '0;
    r.kind        = KIND_END;
    r.delta_ticks = delta;
    r.end_reason  = reason;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mtep_in_if.sv
// Input channel: one track body byte per transaction.
`default_nettype none

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/mtep_out_if.sv
// Output channel: one parsed event or track end per transaction.
`default_nettype none

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [27:0] delta_ticks;
  logic [7:0]  status_byte;
  logic [7:0]  first_param;
  logic [7:0]  second_param;
  logic [1:0]  data_read;
  logic [23:0] tempo_us;
  logic [1:0]  end_reason;

  modport source (output valid, output kind, output delta_ticks, output status_byte,
                  output first_param, output second_param, output data_read,
                  output tempo_us, output end_reason, input ready);
  modport sink (input valid, input kind, input delta_ticks, input status_byte,
                input first_param, input second_param, input data_read,
                input tempo_us, input end_reason, output ready);
endinterface

`default_nettype wire

// File: hdl/mtep_decode.sv
// Combinational decode of one track byte: next parser state and optional result.
`default_nettype none

module mtep_decode
  import mtep_pkg::*;
(
  input  wire parse_state_t     state_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [LEN_W-1:0] track_length_i,
  output parse_state_t          state_o,
  output logic                  emit_o,
  output result_t               result_o
);

  logic [LEN_W-1:0]   pos_n;
  logic               at_last;
  logic [VLQ_W-1:0]   vlq_nv;
  vlq_e               vlq_res;
  logic [LEN_W-1:0]   bytes_left;
  logic               len_past;
  logic               len_bad;
  logic [1:0]         bnd_reason;
  logic [1:0]         got_n;
  logic [LEN_W-1:0]   skip_dec;
  logic [7:0]         p0_n;
  logic [7:0]         p1_n;
  logic [TEMPO_W-1:0] tempo_n;
  logic               is_sysex;
  logic               tempo_meta;
  logic               end_meta;

  // Shared arithmetic on the current byte.
  always_comb begin
    pos_n      = state_i.byte_pos + LEN_W'(1);
    at_last    = (pos_n >= track_length_i);
    vlq_nv     = {state_i.vlq_value[VLQ_W-8:0], data_byte_i[6:0]};
    if (|state_i.vlq_value[VLQ_W-1:VLQ_W-7]) begin
      vlq_res = VLQ_BAD;
    end else if (!data_byte_i[7]) begin
      vlq_res = VLQ_DONE;
    end else if (at_last) begin
      vlq_res = VLQ_BAD;
    end else begin
      vlq_res = VLQ_MORE;
    end
    bytes_left = track_length_i - pos_n;
    len_past   = ({{(LEN_W-VLQ_W){1'b0}}, vlq_nv} > bytes_left);
    len_bad    = (vlq_res == VLQ_BAD) || (vlq_res == VLQ_DONE && len_past);
    bnd_reason = at_last ? REASON_DATA_END : REASON_RUNNING;
    got_n      = state_i.params_got + 2'd1;
    skip_dec   = (state_i.skip_remaining != '0) ? state_i.skip_remaining - LEN_W'(1) : '0;
    p0_n       = state_i.params_got[0] ? state_i.param0 : data_byte_i;
    p1_n       = state_i.params_got[0] ? data_byte_i : state_i.param1;
    tempo_n    = {state_i.tempo_acc[TEMPO_W-9:0], data_byte_i};
    is_sysex   = data_byte_i inside {SYSEX_START, SYSEX_ESCAPE};
    tempo_meta = (state_i.phase == PH_META_LEN) && (state_i.meta_kind == META_TEMPO) &&
                 (vlq_nv == VLQ_W'(3));
    end_meta   = (state_i.phase == PH_META_LEN) && (state_i.meta_kind == META_END);
  end

  // Next parser state.
  always_comb begin
    state_o = state_i;

    if (state_i.track_done) begin
      // Bytes after the end are dropped.
      state_o = state_i;
    end else if (state_i.byte_pos >= track_length_i) begin
      // A byte beyond the length is not consumed.
      state_o.track_done = 1'b1;
    end else begin
      state_o.byte_pos = pos_n;
      case (state_i.phase)
        PH_DELTA: begin
          state_o.vlq_value = vlq_nv;
          if (vlq_res == VLQ_BAD) begin
            state_o.track_done = 1'b1;
          end else if (vlq_res == VLQ_DONE) begin
            state_o.pending_delta = vlq_nv;
            if (at_last) begin
              state_o.track_done = 1'b1;
            end else begin
              state_o.phase = PH_EVENT;
            end
          end
        end

        PH_EVENT: begin
          state_o.param0     = '0;
          state_o.param1     = '0;
          state_o.params_got = '0;
          if (data_byte_i == META_BYTE) begin
            state_o.run_status = '0;
            if (at_last) begin
              state_o.track_done = 1'b1;
            end else begin
              state_o.phase = PH_META_TYPE;
            end
          end else if (is_sysex) begin
            state_o.run_status = '0;
            state_o.vlq_value  = '0;
            if (at_last) begin
              state_o.track_done = 1'b1;
            end else begin
              state_o.phase = PH_SYSEX_LEN;
            end
          end else if (data_byte_i[7]) begin
            // Explicit status byte.
            state_o.run_status  = data_byte_i;
            state_o.data_needed = needed_for(data_byte_i);
            if (at_last) begin
              state_o.track_done = 1'b1;
            end else begin
              state_o.phase = PH_PARAMS;
            end
          end else begin
            // Data byte under running status.
            state_o.data_needed = needed_for(state_i.run_status);
            state_o.param0      = data_byte_i;
            state_o.params_got  = 2'd1;
            if (needed_for(state_i.run_status) == 2'd1 || at_last) begin
              if (at_last) begin
                state_o.track_done = 1'b1;
              end else begin
                state_o.phase     = PH_DELTA;
                state_o.vlq_value = '0;
              end
            end else begin
              state_o.phase = PH_PARAMS;
            end
          end
        end

        PH_PARAMS: begin
          state_o.param0     = p0_n;
          state_o.param1     = p1_n;
          state_o.params_got = got_n;
          if (got_n >= state_i.data_needed || at_last) begin
            if (at_last) begin
              state_o.track_done = 1'b1;
            end else begin
              state_o.phase     = PH_DELTA;
              state_o.vlq_value = '0;
            end
          end
        end

        PH_META_TYPE: begin
          state_o.meta_kind = data_byte_i;
          state_o.vlq_value = '0;
          if (at_last) begin
            state_o.track_done = 1'b1;
          end else begin
            state_o.phase = PH_META_LEN;
          end
        end

        PH_META_LEN, PH_SYSEX_LEN: begin
          state_o.vlq_value = vlq_nv;
          if (len_bad) begin
            state_o.track_done = 1'b1;
          end else if (vlq_res == VLQ_DONE) begin
            if (tempo_meta) begin
              state_o.tempo_acc      = '0;
              state_o.skip_remaining = LEN_W'(3);
              state_o.phase          = PH_TEMPO;
            end else if (end_meta) begin
              state_o.track_done = 1'b1;
            end else if (vlq_nv == '0) begin
              if (at_last) begin
                state_o.track_done = 1'b1;
              end else begin
                state_o.phase     = PH_DELTA;
                state_o.vlq_value = '0;
              end
            end else begin
              state_o.skip_remaining = {{(LEN_W-VLQ_W){1'b0}}, vlq_nv};
              state_o.phase          = PH_SKIP;
            end
          end
        end

        PH_TEMPO, PH_SKIP: begin
          if (state_i.phase == PH_TEMPO) begin
            state_o.tempo_acc = tempo_n;
          end
          state_o.skip_remaining = skip_dec;
          if (skip_dec == '0) begin
            if (at_last) begin
              state_o.track_done = 1'b1;
            end else begin
              state_o.phase     = PH_DELTA;
              state_o.vlq_value = '0;
            end
          end
        end

        default: begin
          state_o.phase     = PH_DELTA;
          state_o.vlq_value = '0;
        end
      endcase
    end
  end

  // Result for the current byte, if it completes an event or ends the track.
  always_comb begin
    emit_o   = 1'b0;
    result_o = '0;

    if (!state_i.track_done) begin
      if (state_i.byte_pos >= track_length_i) begin
        emit_o   = 1'b1;
        result_o = end_item('0, REASON_DATA_END);
      end else begin
        case (state_i.phase)
          PH_DELTA: begin
            if (vlq_res == VLQ_BAD) begin
              emit_o   = 1'b1;
              result_o = end_item('0, REASON_MALFORMED);
            end else if (vlq_res == VLQ_DONE && at_last) begin
              emit_o   = 1'b1;
              result_o = end_item(vlq_nv, REASON_DATA_END);
            end
          end

          PH_EVENT: begin
            if (data_byte_i == META_BYTE) begin
              if (at_last) begin
                emit_o   = 1'b1;
                result_o = end_item(state_i.pending_delta, REASON_DATA_END);
              end
            end else if (is_sysex) begin
              if (at_last) begin
                emit_o   = 1'b1;
                result_o = end_item(state_i.pending_delta, REASON_MALFORMED);
              end
            end else if (data_byte_i[7]) begin
              // Status byte on the last body byte: event with no data.
              if (at_last) begin
                emit_o               = 1'b1;
                result_o.kind        = KIND_CHANNEL;
                result_o.delta_ticks = state_i.pending_delta;
                result_o.status_byte = data_byte_i;
                result_o.end_reason  = REASON_DATA_END;
              end
            end else if (needed_for(state_i.run_status) == 2'd1 || at_last) begin
              emit_o               = 1'b1;
              result_o.kind        = KIND_CHANNEL;
              result_o.delta_ticks = state_i.pending_delta;
              result_o.status_byte = state_i.run_status;
              result_o.first_param = data_byte_i;
              result_o.data_read   = 2'd1;
              result_o.end_reason  = bnd_reason;
            end
          end

          PH_PARAMS: begin
            if (got_n >= state_i.data_needed || at_last) begin
              emit_o                = 1'b1;
              result_o.kind         = KIND_CHANNEL;
              result_o.delta_ticks  = state_i.pending_delta;
              result_o.status_byte  = state_i.run_status;
              result_o.first_param  = (got_n > 2'd0) ? p0_n : 8'd0;
              result_o.second_param = (got_n > 2'd1) ? p1_n : 8'd0;
              result_o.data_read    = got_n;
              result_o.end_reason   = bnd_reason;
            end
          end

          PH_META_TYPE: begin
            if (at_last) begin
              emit_o   = 1'b1;
              result_o = end_item(state_i.pending_delta, REASON_MALFORMED);
            end
          end

          PH_META_LEN, PH_SYSEX_LEN: begin
            if (len_bad) begin
              emit_o   = 1'b1;
              result_o = end_item(state_i.pending_delta, REASON_MALFORMED);
            end else if (vlq_res == VLQ_DONE) begin
              if (end_meta) begin
                emit_o   = 1'b1;
                result_o = end_item(state_i.pending_delta, REASON_END_META);
              end else if (vlq_nv == '0 && at_last) begin
                emit_o   = 1'b1;
                result_o = end_item(state_i.pending_delta, REASON_DATA_END);
              end
            end
          end

          PH_TEMPO: begin
            if (skip_dec == '0) begin
              emit_o               = 1'b1;
              result_o.kind        = KIND_TEMPO;
              result_o.delta_ticks = state_i.pending_delta;
              result_o.tempo_us    = tempo_n;
              result_o.end_reason  = bnd_reason;
            end
          end

          PH_SKIP: begin
            if (skip_dec == '0 && at_last) begin
              emit_o   = 1'b1;
              result_o = end_item(state_i.pending_delta, REASON_DATA_END);
            end
          end

          default: begin
            emit_o = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/midi_track_event_parser.sv
// Top level of the MIDI track event parser: registers, handshake and configuration.
`default_nettype none

// The parser takes a MIDI track body one byte per transaction and reports channel
// events, tempo changes and the end of the track. Write the body length to the
// track length register before the first byte; reset restarts the parse. Each byte
// is decoded in the cycle it is accepted and any result appears in the output
// register on the next cycle, so one byte is taken every clock as long as the
// output register is empty or being drained in the same cycle. A byte gives at
// most one result; after the end is reported, further bytes are taken and dropped.

module midi_track_event_parser
  import mtep_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  mtep_in_if.sink          in_if,
  mtep_out_if.source       out_if
);

  parse_state_t     state_q;
  parse_state_t     state_d;
  logic [LEN_W-1:0] track_length_q;
  logic             out_valid_q;
  result_t          out_data_q;
  result_t          result_d;
  logic             emit_d;
  logic             in_fire;

  // A byte is taken whenever the output register is free or draining.
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  mtep_decode u_decode (
    .state_i        (state_q),
    .data_byte_i    (in_if.data_byte),
    .track_length_i (track_length_q),
    .state_o        (state_d),
    .emit_o         (emit_d),
    .result_o       (result_d)
  );

  // Track length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_length_q <= '0;
    end else if (cfg_we_i) begin
      track_length_q <= cfg_wdata_i;
    end
  end

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit_d) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (in_fire && emit_d) begin
      out_data_q <= result_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.kind         = out_data_q.kind;
  assign out_if.delta_ticks  = out_data_q.delta_ticks;
  assign out_if.status_byte  = out_data_q.status_byte;
  assign out_if.first_param  = out_data_q.first_param;
  assign out_if.second_param = out_data_q.second_param;
  assign out_if.data_read    = out_data_q.data_read;
  assign out_if.tempo_us     = out_data_q.tempo_us;
  assign out_if.end_reason   = out_data_q.end_reason;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the MIDI track event parser, fed with generated track bodies.
`timescale 1ns / 1ps

module testbench
  import mtep_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 360;
  localparam int unsigned HOLD_AT_RESULT = 60;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;

  mtep_in_if byte_if();
  mtep_out_if event_if();

  midi_track_event_parser DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if(byte_if),
    .out_if(event_if)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser state as predicted from the bytes taken so far.
  phase_e ph = PH_DELTA;
  logic [7:0] run_status = '0;
  logic [27:0] vlq_acc = '0;
  logic [27:0] delta_pending = '0;
  logic [7:0] meta_code = '0;
  logic [31:0] skip_left = '0;
  logic [7:0] par [2] = '{8'h00, 8'h00};
  logic [1:0] par_needed = '0;
  logic [1:0] par_got = '0;
  logic [23:0] tempo_acc = '0;
  logic [31:0] body_pos = '0;
  logic [31:0] body_len = '0;
  bit done = 1'b0;

  // Parsed events still to come out of the block, oldest first.
  result_t expected_events [$];

  // Track body bytes waiting to be offered to the block.
  logic [7:0] pending_bytes [$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned phase_bytes = 0;
  logic [7:0] gen_running = '0;

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  logic [31:0] cycle_count = '0;
  bit quiet_run = 1'b0;

  function automatic logic [1:0] param_count(input logic [7:0] st);
    return (st[7:4] == TYPE_PROGRAM || st[7:4] == TYPE_PRESSURE) ? 2'd1 : 2'd2;
  endfunction

  // Record a track end that carries no event.
  function automatic void push_end(input logic [27:0] delta, input logic [1:0] reason);
    result_t r;
    r = '0;
    r.kind = KIND_END;
    r.delta_ticks = delta;
    r.end_reason = reason;
    done = 1'b1;
    expected_events.push_back(r);
  endfunction

  // An element is complete: either the body is used up or a new delta starts.
  function automatic logic [1:0] close_element();
    if (body_pos >= body_len) begin
      done = 1'b1;
      return REASON_DATA_END;
    end
    ph = PH_DELTA;
    vlq_acc = '0;
    return REASON_RUNNING;
  endfunction

  function automatic void finish_element();
    logic [1:0] reason;
    reason = close_element();
    if (reason != REASON_RUNNING) begin
      push_end(delta_pending, reason);
    end
  endfunction

  // Fold one byte into a variable-length quantity.
  function automatic vlq_e vlq_take(input logic [7:0] b);
    logic [34:0] widened;
    widened = {vlq_acc, b[6:0]};
    if (widened > 35'h0FFF_FFFF) begin
      return VLQ_BAD;
    end
    vlq_acc = widened[27:0];
    if (!b[7]) begin
      return VLQ_DONE;
    end
    if (body_pos >= body_len) begin
      return VLQ_BAD;
    end
    return VLQ_MORE;
  endfunction

  function automatic void emit_channel();
    result_t r;
    r = '0;
    r.kind = KIND_CHANNEL;
    r.delta_ticks = delta_pending;
    r.status_byte = run_status;
    r.first_param = (par_got > 0) ? par[0] : 8'h00;
    r.second_param = (par_got > 1) ? par[1] : 8'h00;
    r.data_read = par_got;
    r.end_reason = close_element();
    expected_events.push_back(r);
  endfunction

  // Advance the predicted parser by one accepted byte.
  function automatic void parse_byte(input logic [7:0] b);
    vlq_e outcome;
    logic [31:0] room;
    result_t r;
    if (done) begin
      return;
    end
    if (body_pos >= body_len) begin
      push_end('0, REASON_DATA_END);
      return;
    end
    body_pos++;
    case (ph)
      PH_DELTA: begin
        outcome = vlq_take(b);
        if (outcome == VLQ_BAD) begin
          push_end('0, REASON_MALFORMED);
        end else if (outcome == VLQ_DONE) begin
          delta_pending = vlq_acc;
          if (body_pos >= body_len) begin
            push_end(delta_pending, REASON_DATA_END);
          end else begin
            ph = PH_EVENT;
          end
        end
      end
      PH_EVENT: begin
        par[0] = '0;
        par[1] = '0;
        par_got = '0;
        if (b == META_BYTE) begin
          run_status = '0;
          if (body_pos >= body_len) begin
            push_end(delta_pending, REASON_DATA_END);
          end else begin
            ph = PH_META_TYPE;
          end
        end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
          run_status = '0;
          vlq_acc = '0;
          if (body_pos >= body_len) begin
            push_end(delta_pending, REASON_MALFORMED);
          end else begin
            ph = PH_SYSEX_LEN;
          end
        end else if (b[7]) begin
          run_status = b;
          par_needed = param_count(b);
          if (body_pos >= body_len) begin
            emit_channel();
          end else begin
            ph = PH_PARAMS;
          end
        end else begin
          // Data byte in event position: running status applies.
          par_needed = param_count(run_status);
          par[0] = b;
          par_got = 2'd1;
          if (par_got >= par_needed || body_pos >= body_len) begin
            emit_channel();
          end else begin
            ph = PH_PARAMS;
          end
        end
      end
      PH_PARAMS: begin
        par[par_got[0]] = b;
        par_got++;
        if (par_got >= par_needed || body_pos >= body_len) begin
          emit_channel();
        end
      end
      PH_META_TYPE: begin
        meta_code = b;
        vlq_acc = '0;
        if (body_pos >= body_len) begin
          push_end(delta_pending, REASON_MALFORMED);
        end else begin
          ph = PH_META_LEN;
        end
      end
      PH_META_LEN, PH_SYSEX_LEN: begin
        outcome = vlq_take(b);
        if (outcome == VLQ_BAD) begin
          push_end(delta_pending, REASON_MALFORMED);
        end else if (outcome == VLQ_DONE) begin
          room = (body_pos < body_len) ? body_len - body_pos : '0;
          if ({4'b0, vlq_acc} > room) begin
            push_end(delta_pending, REASON_MALFORMED);
          end else if (ph == PH_META_LEN && meta_code == META_TEMPO && vlq_acc == 28'd3) begin
            tempo_acc = '0;
            skip_left = 32'd3;
            ph = PH_TEMPO;
          end else if (ph == PH_META_LEN && meta_code == META_END) begin
            push_end(delta_pending, REASON_END_META);
          end else if (vlq_acc == '0) begin
            finish_element();
          end else begin
            skip_left = {4'b0, vlq_acc};
            ph = PH_SKIP;
          end
        end
      end
      PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        if (skip_left != 0) begin
          skip_left--;
        end
        if (skip_left == 0) begin
          r = '0;
          r.kind = KIND_TEMPO;
          r.delta_ticks = delta_pending;
          r.tempo_us = tempo_acc;
          r.end_reason = close_element();
          expected_events.push_back(r);
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) begin
          skip_left--;
        end
        if (skip_left == 0) begin
          finish_element();
        end
      end
      default: begin
        ph = PH_DELTA;
        vlq_acc = '0;
      end
    endcase
  endfunction

  // Byte sender: takes bytes from the pending queue, with random gaps.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        parse_byte(byte_if.data_byte);
        bytes_taken++;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_if.valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          byte_if.valid <= 1'b0;
        end else if (!quiet_run && cycle_count[7] && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 3);
          byte_if.valid <= 1'b0;
        end else begin
          byte_if.valid <= 1'b1;
          byte_if.data_byte <= pending_bytes.pop_front();
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Event receiver: checks each transaction and applies back-pressure.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (event_if.valid && event_if.ready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event: expected none, actual kind %0d delta %0d status 0x%0h",
                   $time, event_if.kind, event_if.delta_ticks, event_if.status_byte);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("kind", 32'(want.kind), 32'(event_if.kind));
          check_field("delta_ticks", 32'(want.delta_ticks), 32'(event_if.delta_ticks));
          check_field("status_byte", 32'(want.status_byte), 32'(event_if.status_byte));
          check_field("first_param", 32'(want.first_param), 32'(event_if.first_param));
          check_field("second_param", 32'(want.second_param), 32'(event_if.second_param));
          check_field("data_read", 32'(want.data_read), 32'(event_if.data_read));
          check_field("tempo_us", 32'(want.tempo_us), 32'(event_if.tempo_us));
          check_field("end_reason", 32'(want.end_reason), 32'(event_if.end_reason));
        end
      end
      // One long hold-off lets the output fill and the input stall.
      if (hold_left > 0) begin
        hold_left--;
        event_if.ready <= 1'b0;
      end else if (results_seen == HOLD_AT_RESULT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        event_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        event_if.ready <= 1'b0;
      end else if (!quiet_run && cycle_count[8] && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        event_if.ready <= 1'b0;
      end else begin
        event_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
    phase_bytes++;
  endtask

  // Variable-length quantity, most significant group first, with optional 0x80 padding.
  task automatic push_vlq(input logic [27:0] value, input int unsigned pad);
    logic [6:0] groups [4];
    int unsigned used;
    used = 1;
    for (int k = 0; k < 4; k++) begin
      groups[k] = value[7*k +: 7];
      if (groups[k] != 0) begin
        used = k + 1;
      end
    end
    repeat (pad) push_byte(8'h80);
    for (int k = used - 1; k >= 0; k--) begin
      push_byte({k != 0, groups[k]});
    end
  endtask

  function automatic logic [27:0] random_delta();
    case ($urandom_range(0, 9))
      7, 8: return 28'($urandom_range(128, 16383));
      9: return 28'($urandom_range(0, 28'hFFF_FFFF));
      default: return 28'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic int unsigned random_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic push_status_event(input logic [7:0] st);
    push_byte(st);
    gen_running = st;
    repeat (param_count(st)) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Meta event header and content with the given type and length.
  task automatic push_meta(input logic [7:0] mtype, input int unsigned count);
    push_byte(META_BYTE);
    push_byte(mtype);
    push_vlq(28'(count), random_pad());
    repeat (count) push_byte(8'($urandom_range(0, 255)));
    gen_running = '0;
  endtask

  // One delta and one event. With track_end set, events that end the track
  // (end meta, delta overflow, length past the end) may be chosen too.
  task automatic gen_event(input bit track_end);
    int unsigned pick;
    int unsigned count;
    logic [7:0] st;
    pick = $urandom_range(0, track_end ? 13 : 10);
    if (pick == 12) begin
      // Delta that grows past 28 bits.
      push_byte(8'h81);
      repeat (4) push_byte(8'h80);
      return;
    end
    push_vlq(random_delta(), random_pad());
    case (pick)
      0, 1, 2: push_status_event(8'($urandom_range(8'h80, 8'hEF)));
      3: begin
        // System status bytes other than sysex and meta.
        count = $urandom_range(0, 11);
        st = (count < 6) ? 8'(8'hF1 + count) : 8'(8'hF8 + count - 6);
        push_status_event(st);
      end
      4, 5, 6: begin
        push_byte(8'($urandom_range(0, 127)));
        if (param_count(gen_running) == 2'd2) begin
          push_byte(8'($urandom_range(0, 255)));
        end
      end
      7: push_meta(META_TEMPO, 3);
      8: begin
        do st = 8'($urandom_range(0, 255)); while (st == META_END);
        push_meta(st, $urandom_range(0, 6));
      end
      9: begin
        push_byte($urandom_range(0, 1) ? SYSEX_START : SYSEX_ESCAPE);
        count = ($urandom_range(0, 15) == 0) ? $urandom_range(130, 200) : $urandom_range(0, 6);
        push_vlq(28'(count), random_pad());
        repeat (count) push_byte(8'($urandom_range(0, 255)));
        gen_running = '0;
      end
      10: begin
        // Tempo meta with a length other than three is skipped.
        count = $urandom_range(0, 4);
        if (count >= 3) begin
          count++;
        end
        push_meta(META_TEMPO, count);
      end
      11: push_meta(META_END, $urandom_range(0, 3));
      default: begin
        push_byte(META_BYTE);
        push_byte(8'($urandom_range(0, 255)));
        push_vlq(28'h0FFF_FFFF - 28'($urandom_range(0, 100)), 0);
        gen_running = '0;
      end
    endcase
  endtask

  task automatic write_length(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    body_len = value;
  endtask

  // Wait until every byte is taken and every predicted event has come out.
  task automatic drain();
    do @(posedge clk_i);
    while (bytes_taken != bytes_queued || expected_events.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned slack;
    logic [7:0] opening [$];
    opening = '{
      8'h00, 8'hF3, 8'h80, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h00, 8'h7F,
      8'h80, 8'h00, 8'h55, 8'h01,
      8'h00, 8'hC3, 8'hFF,
      8'h00, 8'hF7, 8'h00,
      8'h00, 8'h12, 8'h34,
      8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF
    };
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    event_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: field extremes, system status, padded delta, running
    // status, a one-byte event, data without running status and a tempo change.
    write_length(32'hFFFF_FFFF);
    foreach (opening[i]) push_byte(opening[i]);
    gen_running = '0;
    drain();

    // Random well-formed stream over several length settings.
    for (int p = 0; p < 4; p++) begin
      case (p)
        1: write_length(32'hFFFF_FFFF);
        default: write_length(body_pos + $urandom_range(2000, 32'h7FFF_0000));
      endcase
      quiet_run = (p == 3);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) gen_event(1'b0);
      drain();
    end

    // Cut the body short a little ahead and let the track end somewhere in it.
    slack = $urandom_range(0, 60);
    write_length(body_pos + slack);
    phase_bytes = 0;
    while (phase_bytes <= slack + 8) gen_event(1'b1);
    drain();

    // After the end, bytes are dropped whatever the length says.
    write_length('0);
    repeat (5) push_byte(8'($urandom_range(0, 255)));
    drain();

    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
